@@ hdl/frame_ring_buffer_allocator_macros.svh @@
// Assertion macros used by the frame ring buffer allocator top level.
`ifndef FRAME_RING_BUFFER_ALLOCATOR_MACROS_SVH
`define FRAME_RING_BUFFER_ALLOCATOR_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FRBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FRBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/frba_pkg.sv @@
// Types, constants and helper functions of the frame ring buffer allocator.
package frba_pkg;

  // Sizing of the ring pointers and the frame mark queue.
  localparam int MARK_DEPTH    = 8;
  localparam int OFFSET_BITS   = 31;
  localparam int MARK_IDX_BITS = $clog2(MARK_DEPTH);
  localparam int MARK_CNT_BITS = $clog2(MARK_DEPTH + 1);

  // Fixed widths of the port fields.
  localparam int FUNC_BITS    = 2;
  localparam int BYTES_BITS   = 31;
  localparam int LOG2_BITS    = 5;
  localparam int FRAME_BITS   = 48;
  localparam int STATUS_BITS  = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 31;

  // Aligned tail needs one more bit; the fit sum one more again.
  localparam int AT_BITS  = OFFSET_BITS + 1;
  localparam int SUM_BITS = ((AT_BITS > BYTES_BITS) ? AT_BITS : BYTES_BITS) + 1;
  localparam int MARK_BITS = FRAME_BITS + OFFSET_BITS;

  // Operation codes of an input word.
  localparam logic [FUNC_BITS-1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SET_FRAME = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_COMPLETE  = 2'd2;

  // Status codes of a result word.
  localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_OOM  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_RING_SIZE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ALIGN  = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [OFFSET_BITS-1:0] RING_SIZE_RESET = OFFSET_BITS'(1048576);
  localparam logic [LOG2_BITS-1:0]   MIN_ALIGN_RESET = LOG2_BITS'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FRAME,
    ST_POP_RD,
    ST_POP_CHK,
    ST_IGNORE
  } state_t;

  // One entry of the frame mark queue.
  typedef struct packed {
    logic [FRAME_BITS-1:0]  frame;
    logic [OFFSET_BITS-1:0] tail;
  } mark_t;

  // Placement decision of the allocation unit.
  typedef struct packed {
    logic                   ok;
    logic [OFFSET_BITS-1:0] where;
    logic [OFFSET_BITS-1:0] new_tail;
  } alloc_res_t;

  // Rounds v up to a multiple of 2**lg. Alignments beyond the pointer width
  // give the same placement as the pointer width itself.
  function automatic logic [AT_BITS-1:0] align_up(input logic [OFFSET_BITS-1:0] v,
                                                  input logic [LOG2_BITS-1:0] lg);
    logic [AT_BITS-1:0] one;
    logic [AT_BITS-1:0] mask;
    one = AT_BITS'(1);
    if (int'(lg) > OFFSET_BITS) begin
      mask = (one << OFFSET_BITS) - one;
    end else begin
      mask = (one << lg) - one;
    end
    return (AT_BITS'(v) + mask) & ~mask;
  endfunction

endpackage

@@ hdl/frba_mark_ram.sv @@
// Simple dual-port RAM with a registered read port, holding the frame marks.
module frba_mark_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 8,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/frba_alloc.sv @@
// Placement unit: decides where an allocation goes and the new tail.
module frba_alloc
  import frba_pkg::*;
(
  input  logic [AT_BITS-1:0]     at,
  input  logic [BYTES_BITS-1:0]  byte_count,
  input  logic [OFFSET_BITS-1:0] head,
  input  logic [OFFSET_BITS-1:0] tail,
  input  logic [OFFSET_BITS-1:0] ring_size,
  output alloc_res_t             res
);

  logic [SUM_BITS-1:0] end_at;
  logic [SUM_BITS-1:0] n_wide;
  logic [SUM_BITS-1:0] head_wide;

  assign end_at    = SUM_BITS'(at) + SUM_BITS'(byte_count);
  assign n_wide    = SUM_BITS'(byte_count);
  assign head_wide = SUM_BITS'(head);

  // Place at the aligned tail, else wrap to offset zero, else fail.
  // Both tests against head are strict so that a full ring never looks empty.
  always_comb begin
    res.ok       = 1'b0;
    res.where    = '0;
    res.new_tail = tail;
    if (tail >= head) begin
      if (end_at <= SUM_BITS'(ring_size)) begin
        res.ok       = 1'b1;
        res.where    = OFFSET_BITS'(at);
        res.new_tail = OFFSET_BITS'(end_at);
      end else if (n_wide < head_wide) begin
        res.ok       = 1'b1;
        res.new_tail = OFFSET_BITS'(byte_count);
      end
    end else if (end_at < head_wide) begin
      res.ok       = 1'b1;
      res.where    = OFFSET_BITS'(at);
      res.new_tail = OFFSET_BITS'(end_at);
    end
  end

endmodule

@@ hdl/frame_ring_buffer_allocator.sv @@
// Top level of the ring suballocator with frame-based reclaim.
//
//   channel  direction  handshake               words carried
//   req      in         req_valid / req_stall   func, byte_count, align_log2, frame_number
//   rsp      out        rsp_valid / rsp_stall   status, offset, frame_tag, head/tail_offset
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Allocate, set-frame and unknown words pass the accept cycle, which also aligns the
// tail, then a state that places the block, pushes a mark or ignores the word.
// A completion alternates a read state and a check state for each mark that it pops,
// and ends at a newer mark or an empty queue; each check waits on the mark RAM read.
// Synchronous reset clears config, state, pointers, frame and queue, not data or mark RAM.
// A new word is taken while a result waits; a word finishes once that result has left.
`include "frame_ring_buffer_allocator_macros.svh"

module frame_ring_buffer_allocator
  import frba_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [FUNC_BITS-1:0]    func,
  input  logic [BYTES_BITS-1:0]   byte_count,
  input  logic [LOG2_BITS-1:0]    align_log2,
  input  logic [FRAME_BITS-1:0]   frame_number,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [STATUS_BITS-1:0]  status,
  output logic [BYTES_BITS-1:0]   offset,
  output logic [FRAME_BITS-1:0]   frame_tag,
  output logic [BYTES_BITS-1:0]   head_offset,
  output logic [BYTES_BITS-1:0]   tail_offset,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  state_t state, state_next;

  logic [OFFSET_BITS-1:0]   ring_size;
  logic [LOG2_BITS-1:0]     min_align;
  logic [OFFSET_BITS-1:0]   head_ptr, head_next;
  logic [OFFSET_BITS-1:0]   tail_ptr, tail_next;
  logic [FRAME_BITS-1:0]    cur_frame, cur_frame_next;
  logic [MARK_IDX_BITS-1:0] mark_rd, mark_rd_next;
  logic [MARK_CNT_BITS-1:0] mark_count, mark_count_next;

  // Captured input word and its aligned tail.
  logic [BYTES_BITS-1:0]    item_bytes;
  logic [FRAME_BITS-1:0]    item_frame;
  logic [AT_BITS-1:0]       item_at;
  logic [LOG2_BITS-1:0]     eff_align;

  // Result of the word being finished.
  logic                     finish;
  logic                     rsp_free;
  logic [STATUS_BITS-1:0]   res_status;
  logic [OFFSET_BITS-1:0]   res_offset;

  // Mark queue access.
  logic                     mark_we;
  logic [MARK_IDX_BITS-1:0] mark_waddr;
  mark_t                    mark_wdata;
  mark_t                    mark_rdata;
  logic [MARK_BITS-1:0]     mark_rword;
  logic [MARK_CNT_BITS:0]   slot_sum;
  logic [MARK_IDX_BITS-1:0] rd_inc;

  alloc_res_t               alloc_res;

  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign eff_align = (align_log2 > min_align) ? align_log2 : min_align;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= RING_SIZE_RESET;
      min_align <= MIN_ALIGN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RING_SIZE: ring_size <= OFFSET_BITS'(cfg_data);
        CFG_MIN_ALIGN: min_align <= cfg_data[LOG2_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The mark queue lives in a RAM; the read port always looks at the oldest mark.
  frba_mark_ram #(
    .WIDTH (MARK_BITS),
    .DEPTH (MARK_DEPTH)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_rd),
    .rdata (mark_rword)
  );

  assign mark_rdata = mark_t'(mark_rword);

  frba_alloc u_alloc (
    .at         (item_at),
    .byte_count (item_bytes),
    .head       (head_ptr),
    .tail       (tail_ptr),
    .ring_size  (ring_size),
    .res        (alloc_res)
  );

  // Free slot behind the newest mark, and the slot after the oldest.
  assign slot_sum = (MARK_CNT_BITS + 1)'(mark_rd) + (MARK_CNT_BITS + 1)'(mark_count);
  assign mark_waddr = (slot_sum >= (MARK_CNT_BITS + 1)'(MARK_DEPTH))
                      ? MARK_IDX_BITS'(slot_sum - (MARK_CNT_BITS + 1)'(MARK_DEPTH))
                      : MARK_IDX_BITS'(slot_sum);
  assign rd_inc = (mark_rd == MARK_IDX_BITS'(MARK_DEPTH - 1))
                  ? '0 : mark_rd + MARK_IDX_BITS'(1);
  assign mark_wdata.frame = item_frame;
  assign mark_wdata.tail  = tail_ptr;

  // Sequencer: next state, pointer updates and the finished result.
  always_comb begin
    state_next      = state;
    head_next       = head_ptr;
    tail_next       = tail_ptr;
    cur_frame_next  = cur_frame;
    mark_rd_next    = mark_rd;
    mark_count_next = mark_count;
    mark_we         = 1'b0;
    finish          = 1'b0;
    res_status      = STATUS_OK;
    res_offset      = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (func)
            FUNC_ALLOC:     state_next = ST_ALLOC;
            FUNC_SET_FRAME: state_next = ST_FRAME;
            FUNC_COMPLETE:  state_next = ST_POP_RD;
            default:        state_next = ST_IGNORE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (rsp_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
          if (alloc_res.ok) begin
            tail_next  = alloc_res.new_tail;
            res_offset = alloc_res.where;
          end else begin
            res_status = STATUS_OOM;
          end
        end
      end
      ST_FRAME: begin
        if (rsp_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
          if (item_frame > cur_frame) begin
            if (mark_count >= MARK_CNT_BITS'(MARK_DEPTH)) begin
              res_status = STATUS_FULL;
            end else begin
              mark_we         = 1'b1;
              cur_frame_next  = item_frame;
              mark_count_next = mark_count + MARK_CNT_BITS'(1);
            end
          end
        end
      end
      ST_POP_RD: begin
        // The oldest mark is read now and checked in the next cycle.
        if (mark_count != '0) begin
          state_next = ST_POP_CHK;
        end else if (rsp_free) begin
          finish     = 1'b1;
          head_next  = tail_ptr;
          state_next = ST_IDLE;
        end
      end
      ST_POP_CHK: begin
        if (mark_rdata.frame <= item_frame) begin
          mark_rd_next    = rd_inc;
          mark_count_next = mark_count - MARK_CNT_BITS'(1);
          state_next      = ST_POP_RD;
        end else if (rsp_free) begin
          finish     = 1'b1;
          head_next  = mark_rdata.tail;
          state_next = ST_IDLE;
        end
      end
      ST_IGNORE: begin
        if (rsp_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      cur_frame  <= '0;
      mark_rd    <= '0;
      mark_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head_ptr   <= head_next;
      tail_ptr   <= tail_next;
      cur_frame  <= cur_frame_next;
      mark_rd    <= mark_rd_next;
      mark_count <= mark_count_next;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Input word capture; the tail is aligned here so placement has a short path.
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item_bytes <= byte_count;
      item_frame <= frame_number;
      item_at    <= align_up(tail_ptr, eff_align);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (finish) begin
      status      <= res_status;
      offset      <= BYTES_BITS'(res_offset);
      frame_tag   <= cur_frame_next;
      head_offset <= BYTES_BITS'(head_next);
      tail_offset <= BYTES_BITS'(tail_next);
    end
  end

  // The queue never holds more marks than it has entries.
  `FRBA_ASSERT_NOW(a_count_bound, 1'b1, mark_count <= MARK_CNT_BITS'(MARK_DEPTH), "mark count beyond queue depth")
  // Every push into the mark RAM is counted exactly once.
  `FRBA_ASSERT_NEXT(a_push_counted, mark_we, mark_count == $past(mark_count) + MARK_CNT_BITS'(1), "mark push not counted")
  // A mark is only checked for popping while the queue holds one.
  `FRBA_ASSERT_NOW(a_pop_nonempty, state == ST_POP_CHK, mark_count != '0, "pop check on an empty queue")
  // A result is only produced when the result register can take it.
  `FRBA_ASSERT_NOW(a_finish_free, finish, !rsp_valid || !rsp_stall, "result overwrites a waiting word")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the frame ring buffer allocator, with its own reply predictor.
module testbench;
  import frba_pkg::*;

  // Function code that the block ignores, and the field extremes.
  localparam logic [FUNC_BITS-1:0]   FUNC_RESERVED = 2'd3;
  localparam logic [BYTES_BITS-1:0]  BYTES_MAX     = BYTES_BITS'(2147418112);
  localparam logic [CFG_BITS-1:0]    RING_MIN      = CFG_BITS'(65536);
  localparam logic [CFG_BITS-1:0]    RING_MAX      = CFG_BITS'(2147418112);
  localparam logic [FRAME_BITS-1:0]  FRAME_MAX     = {FRAME_BITS{1'b1}};

  // One reply word as the block should give it.
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [BYTES_BITS-1:0]  offset;
    logic [FRAME_BITS-1:0]  frame_tag;
    logic [BYTES_BITS-1:0]  head;
    logic [BYTES_BITS-1:0]  tail;
  } alloc_reply_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  logic [FUNC_BITS-1:0]    func = '0;
  logic [BYTES_BITS-1:0]   byte_count = '0;
  logic [LOG2_BITS-1:0]    align_log2 = '0;
  logic [FRAME_BITS-1:0]   frame_number = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  logic [STATUS_BITS-1:0]  status;
  logic [BYTES_BITS-1:0]   offset;
  logic [FRAME_BITS-1:0]   frame_tag;
  logic [BYTES_BITS-1:0]   head_offset;
  logic [BYTES_BITS-1:0]   tail_offset;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  // Predictor copy of the configuration and of the allocator state.
  logic [OFFSET_BITS-1:0] cap_bytes   = RING_SIZE_RESET;
  logic [LOG2_BITS-1:0]   floor_align = MIN_ALIGN_RESET;
  logic [OFFSET_BITS-1:0] ring_head   = '0;
  logic [OFFSET_BITS-1:0] ring_tail   = '0;
  logic [FRAME_BITS-1:0]  live_frame  = '0;
  logic [FRAME_BITS-1:0]  pend_frame [MARK_DEPTH];
  logic [OFFSET_BITS-1:0] pend_tail  [MARK_DEPTH];
  int                     pend_first  = 0;
  int                     pend_count  = 0;

  alloc_reply_t awaited_replies[$];
  int mismatches = 0;

  // Sender burst shaping and receiver hold-off requests.
  int gap_max     = 6;
  int burst_left  = 0;
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int stall_phase = 0;
  int stall_mode  = 0;

  frame_ring_buffer_allocator uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .func(func), .byte_count(byte_count), .align_log2(align_log2),
    .frame_number(frame_number),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .offset(offset), .frame_tag(frame_tag),
    .head_offset(head_offset), .tail_offset(tail_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Works out the reply to one word and advances the predicted state.
  function automatic alloc_reply_t compute_reply(input logic [FUNC_BITS-1:0] op,
                                                 input logic [BYTES_BITS-1:0] n,
                                                 input logic [LOG2_BITS-1:0] lg_req,
                                                 input logic [FRAME_BITS-1:0] f);
    alloc_reply_t r;
    logic [LOG2_BITS-1:0] lg;
    logic [63:0] mask;
    logic [63:0] at;
    logic [63:0] fit_end;
    int slot;
    r = '0;
    case (op)
      FUNC_ALLOC: begin
        lg = (floor_align > lg_req) ? floor_align : lg_req;
        mask = (64'd1 << lg) - 64'd1;
        at = (64'(ring_tail) + mask) & ~mask;
        fit_end = at + 64'(n);
        if (ring_tail >= ring_head) begin
          if (fit_end <= 64'(cap_bytes)) begin
            r.offset = at[BYTES_BITS-1:0];
            ring_tail = fit_end[OFFSET_BITS-1:0];
          end else if (n < ring_head) begin
            // Wrapped to the start of the ring.
            r.offset = '0;
            ring_tail = n;
          end else begin
            r.status = STATUS_OOM;
          end
        end else if (fit_end < 64'(ring_head)) begin
          r.offset = at[BYTES_BITS-1:0];
          ring_tail = fit_end[OFFSET_BITS-1:0];
        end else begin
          r.status = STATUS_OOM;
        end
      end
      FUNC_SET_FRAME: begin
        // An older or equal frame is dropped silently.
        if (f > live_frame) begin
          if (pend_count >= MARK_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            live_frame = f;
            slot = (pend_first + pend_count) % MARK_DEPTH;
            pend_frame[slot] = f;
            pend_tail[slot] = ring_tail;
            pend_count++;
          end
        end
      end
      FUNC_COMPLETE: begin
        while (pend_count > 0 && pend_frame[pend_first] <= f) begin
          pend_first = (pend_first + 1) % MARK_DEPTH;
          pend_count--;
        end
        ring_head = (pend_count > 0) ? pend_tail[pend_first] : ring_tail;
      end
      default: begin
      end
    endcase
    r.frame_tag = live_frame;
    r.head = ring_head;
    r.tail = ring_tail;
    return r;
  endfunction

  // Offers one request word in the current burst and records its reply.
  task automatic send_word(input logic [FUNC_BITS-1:0] op, input logic [BYTES_BITS-1:0] n,
                           input logic [LOG2_BITS-1:0] lg, input logic [FRAME_BITS-1:0] f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    func <= op;
    byte_count <= n;
    align_log2 <= lg;
    frame_number <= f;
    do @(posedge clk); while (req_stall !== 1'b0);
    awaited_replies = {awaited_replies, compute_reply(op, n, lg, f)};
  endtask

  // Stops offering words and waits for every outstanding reply.
  task automatic settle();
    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Writes one register; the caller lowers the valid after the last write.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_RING_SIZE) begin
      cap_bytes = value;
    end else if (idx == CFG_MIN_ALIGN) begin
      floor_align = value[LOG2_BITS-1:0];
    end
  endtask

  task automatic apply_settings(input logic [CFG_BITS-1:0] size, input int min_lg);
    settle();
    write_reg(CFG_RING_SIZE, size);
    write_reg(CFG_MIN_ALIGN, CFG_BITS'(min_lg));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTES_BITS-1:0] random_bytes();
    return BYTES_BITS'($urandom_range(0, BYTES_MAX));
  endfunction

  function automatic logic [FRAME_BITS-1:0] random_frame();
    return FRAME_BITS'({$urandom, $urandom});
  endfunction

  // Mostly small blocks so the ring wraps and fills, now and then a huge one.
  function automatic logic [BYTES_BITS-1:0] pick_size();
    int unsigned span;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: span = cap_bytes >> 10;
      4, 5, 6:    span = cap_bytes >> 5;
      7, 8:       span = cap_bytes >> 2;
      default:    span = cap_bytes;
    endcase
    return BYTES_BITS'($urandom_range(0, span));
  endfunction

  function automatic logic [LOG2_BITS-1:0] pick_align();
    if ($urandom_range(0, 15) == 0) begin
      return LOG2_BITS'($urandom_range(0, 31));
    end
    return LOG2_BITS'($urandom_range(0, 6));
  endfunction

  // Tail rounded up to the default sixteen-byte alignment.
  function automatic logic [OFFSET_BITS-1:0] tail_on_16();
    return (ring_tail + OFFSET_BITS'(15)) & ~OFFSET_BITS'(15);
  endfunction

  // Frame loops: allocations, new frames and lagging completions, plus some noise.
  task automatic run_frames(input int count);
    int pick;
    int lag;
    logic [FRAME_BITS-1:0] behind;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      lag = $urandom_range(0, 16);
      behind = (live_frame > FRAME_BITS'(lag)) ? live_frame - FRAME_BITS'(lag) : '0;
      if (pick < 58) begin
        send_word(FUNC_ALLOC, pick_size(), pick_align(), random_frame());
      end else if (pick < 74) begin
        send_word(FUNC_SET_FRAME, random_bytes(), LOG2_BITS'($urandom),
                  live_frame + FRAME_BITS'($urandom_range(1, 3)));
      end else if (pick < 86) begin
        send_word(FUNC_COMPLETE, random_bytes(), LOG2_BITS'($urandom), behind);
      end else begin
        case ($urandom_range(0, 4))
          0: send_word(FUNC_RESERVED, random_bytes(), LOG2_BITS'($urandom), random_frame());
          1: send_word(FUNC_ALLOC, random_bytes(), LOG2_BITS'($urandom), random_frame());
          // A frame no newer than the current one.
          2: send_word(FUNC_SET_FRAME, random_bytes(), LOG2_BITS'($urandom), behind);
          3: send_word(FUNC_COMPLETE, random_bytes(), LOG2_BITS'($urandom), random_frame());
          default: send_word(FUNC_COMPLETE, random_bytes(), LOG2_BITS'($urandom),
                             live_frame + FRAME_BITS'(7));
        endcase
      end
    end
  endtask

  // Boundary placements, wrap, strict head test, stale frames and a full mark queue.
  task automatic test_directed_edges();
    for (int k = 0; k < 1; k++) begin
      send_word(FUNC_ALLOC, '0, '0, '0);
    end
    send_word(FUNC_ALLOC, BYTES_BITS'(1), '0, '0);
    send_word(FUNC_ALLOC, BYTES_BITS'(16), LOG2_BITS'(5), '0);
    send_word(FUNC_ALLOC, BYTES_BITS'(16), LOG2_BITS'(31), FRAME_MAX);
    send_word(FUNC_ALLOC, BYTES_MAX, '0, '0);
    // Fill up to the very end of the ring, then nothing more fits.
    send_word(FUNC_ALLOC, cap_bytes - tail_on_16(), LOG2_BITS'(4), '0);
    send_word(FUNC_ALLOC, BYTES_BITS'(1), '0, '0);
    send_word(FUNC_RESERVED, BYTES_MAX, '1, FRAME_MAX);
    send_word(FUNC_SET_FRAME, '0, '0, FRAME_BITS'(1));
    send_word(FUNC_SET_FRAME, '0, '0, FRAME_BITS'(1));
    send_word(FUNC_COMPLETE, '0, '0, '0);
    send_word(FUNC_ALLOC, BYTES_BITS'(100), '0, '0);
    // Ending exactly at the head must fail; one byte short must fit.
    send_word(FUNC_ALLOC, ring_head - tail_on_16(), '0, '0);
    send_word(FUNC_ALLOC, ring_head - tail_on_16() - OFFSET_BITS'(1), '0, '0);
    for (int k = 2; k <= MARK_DEPTH + 1; k++) begin
      send_word(FUNC_SET_FRAME, '0, '0, FRAME_BITS'(k));
    end
    send_word(FUNC_COMPLETE, '0, '0, FRAME_BITS'(3));
    send_word(FUNC_COMPLETE, '0, '0, FRAME_MAX);
    send_word(FUNC_COMPLETE, '0, '0, FRAME_BITS'(5));
  endtask

  task automatic test_frame_loops();
    run_frames(400);
  endtask

  // Traffic under several register settings, extremes included, with pointers kept.
  task automatic test_register_sweep();
    apply_settings(RING_MIN, 0);
    run_frames(180);
    apply_settings(RING_MAX, 16);
    run_frames(180);
    apply_settings(RING_MIN, 16);
    run_frames(120);
    repeat (3) begin
      apply_settings(CFG_BITS'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 16 : 32767) << 16),
                     $urandom_range(0, 16));
      run_frames(180);
    end
    apply_settings(RING_SIZE_RESET, int'(MIN_ALIGN_RESET));
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    gap_max = 0;
    hold_asked++;
    run_frames(90);
    gap_max = 6;
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    run_frames(200);
    gap_max = 6;
  endtask

  // The largest frame number, after which every further frame is stale.
  task automatic test_frame_limit();
    send_word(FUNC_COMPLETE, '0, '0, FRAME_MAX - FRAME_BITS'(1));
    send_word(FUNC_SET_FRAME, '0, '0, FRAME_MAX);
    send_word(FUNC_SET_FRAME, '0, '0, FRAME_MAX);
    send_word(FUNC_ALLOC, BYTES_BITS'(64), '0, '0);
    send_word(FUNC_COMPLETE, '0, '0, FRAME_MAX);
  endtask

  // Receiver stall pattern: changing modes, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = 400;
    end
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 3);
    end
    stall_phase--;
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  // Compares every accepted reply word with the oldest awaited one.
  always @(posedge clk) begin : check_replies
    alloc_reply_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: reply word with none awaited: status %0d offset %0d", $time,
                   status, offset);
        end
      end else begin
        want = awaited_replies[0];
        awaited_replies.delete(0);
        if (status !== want.status || offset !== want.offset ||
            frame_tag !== want.frame_tag || head_offset !== want.head ||
            tail_offset !== want.tail) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected status %0d offset %0d frame %0d head %0d tail %0d", $time,
                     want.status, want.offset, want.frame_tag, want.head, want.tail);
            $display("%0t: got      status %0d offset %0d frame %0d head %0d tail %0d", $time,
                     status, offset, frame_tag, head_offset, tail_offset);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_frame_loops();
    test_register_sweep();
    test_backpressure();
    test_back_to_back();
    test_frame_limit();
    settle();
    // Let any stray reply word show itself.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
